// File: rtl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int COLOR_W   = 8;
  localparam int IDX_W     = 8;
  localparam int CNT_W     = 9;
  localparam int SQ_W      = 2 * COLOR_W;
  localparam int DIST_W    = SQ_W + 2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } npc_state_t;

endpackage

`default_nettype wire

// File: rtl/nearest_palette_color_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Palette memory with a sequential squared-distance search for the closest
// entry to a queried RGB pixel.
// ----------------------------------------------------------------------------
// A load beat (in_kind = 0) writes one palette entry in its accept cycle and
// keeps busy low, so beats may follow every cycle. A query beat (in_kind = 1)
// reads the palette one entry per cycle through the single memory read port:
// with n entries in use it holds busy through the read and drain states
// after the accept edge, and the result appears on out_palette_index with
// out_strobe high in the first cycle with busy low again, in which the next
// beat can already be accepted. The strobe lasts one cycle; there is no stall
// on the result side. entries_in_use of 0 searches one entry, values above
// the palette depth search the whole palette. Loads at an index at or above
// the depth are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_core #(
  parameter int PALETTE_DEPTH = npc_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_kind,
  input  wire logic [npc_pkg::IDX_W-1:0]   in_entry_index,
  input  wire logic [npc_pkg::COLOR_W-1:0] in_red,
  input  wire logic [npc_pkg::COLOR_W-1:0] in_green,
  input  wire logic [npc_pkg::COLOR_W-1:0] in_blue,
  output logic                             out_strobe,
  output logic [npc_pkg::IDX_W-1:0]        out_palette_index,
  input  wire logic                        cfg_wr_en,
  input  wire logic [npc_pkg::CNT_W-1:0]   cfg_wr_data
);

  import npc_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

  // Configuration
  logic [CNT_W-1:0] entries_r;
  logic [CNT_W-1:0] n_eff;
  logic [AW-1:0]    last_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CNT_W'(256);
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (entries_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (entries_r > DEPTH_CNT) begin
      n_eff = DEPTH_CNT;
    end else begin
      n_eff = entries_r;
    end
    last_addr = AW'(n_eff - CNT_W'(1));
  end

  // Control
  npc_state_t state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          accept;
  logic          rd_en;
  logic          load_en;
  logic          query_go;

  assign accept   = start && !busy;
  assign query_go = accept && (in_kind == KIND_QUERY);
  assign load_en  = accept && (in_kind == KIND_LOAD) &&
                    ({1'b0, in_entry_index} < DEPTH_CNT);

  // Pipeline valid/index registers
  logic          v1_r, v2_r, last1_r, last2_r;
  logic [AW-1:0] idx1_r, idx2_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (query_go) state_nxt = ST_READ;
      ST_READ:  if (addr_r == last_addr) state_nxt = ST_DRAIN;
      ST_DRAIN: if (v2_r && last2_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    rd_en    = 1'b0;
    addr_nxt = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        addr_nxt = '0;
      end
      ST_READ: begin
        rd_en    = 1'b1;
        addr_nxt = addr_r + AW'(1);
      end
      ST_DRAIN: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      v1_r    <= rd_en;
      v2_r    <= v1_r;
    end
  end

  // Palette memory, one write and one registered read per cycle
  logic [3*COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [3*COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      pal_mem[AW'(in_entry_index)] <= {in_red, in_green, in_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= pal_mem[addr_r];
    end
  end

  // Pixel latched at query accept
  color_t px_r_r, px_g_r, px_b_r;

  always_ff @(posedge clk) begin
    if (query_go) begin
      px_r_r <= in_red;
      px_g_r <= in_green;
      px_b_r <= in_blue;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r  <= addr_r;
    last1_r <= (addr_r == last_addr);
    idx2_r  <= idx1_r;
    last2_r <= last1_r;
  end

  // Squares stage
  color_t d_r, d_g, d_b;
  color_t e_r, e_g, e_b;
  sq_t    sq_r_r, sq_g_r, sq_b_r;

  assign e_r = rd_data_r[3*COLOR_W-1:2*COLOR_W];
  assign e_g = rd_data_r[2*COLOR_W-1:COLOR_W];
  assign e_b = rd_data_r[COLOR_W-1:0];

  always_comb begin
    d_r = (e_r >= px_r_r) ? (e_r - px_r_r) : (px_r_r - e_r);
    d_g = (e_g >= px_g_r) ? (e_g - px_g_r) : (px_g_r - e_g);
    d_b = (e_b >= px_b_r) ? (e_b - px_b_r) : (px_b_r - e_b);
  end

  always_ff @(posedge clk) begin
    sq_r_r <= d_r * d_r;
    sq_g_r <= d_g * d_g;
    sq_b_r <= d_b * d_b;
  end

  // Sum and compare stage; strict less-than keeps the lowest index on ties
  dist_t         cand_dist;
  dist_t         best_dist_r;
  logic [AW-1:0] best_idx_r;
  logic          take;
  logic [AW-1:0] fin_idx;

  always_comb begin
    cand_dist = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
    take      = (idx2_r == '0) || (cand_dist < best_dist_r);
    fin_idx   = take ? idx2_r : best_idx_r;
  end

  always_ff @(posedge clk) begin
    if (v2_r && take) begin
      best_dist_r <= cand_dist;
      best_idx_r  <= idx2_r;
    end
  end

  // Result register
  logic             out_strobe_r;
  logic [IDX_W-1:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v2_r && last2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && last2_r) begin
      out_idx_r <= IDX_W'(fin_idx);
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_palette_index = out_idx_r;

endmodule

`default_nettype wire

// File: sim/nearest_palette_color_checker.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_checker
// Watches the load/query, result and register ports of the nearest palette
// color core. It keeps its own palette and entry count, works out the closest
// entry for every accepted query and compares each result strobe with the
// oldest outstanding index.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_checker #(
  parameter int PALETTE_DEPTH = npc_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic                        in_kind,
  input  wire logic [npc_pkg::IDX_W-1:0]   in_entry_index,
  input  wire npc_pkg::color_t             in_red,
  input  wire npc_pkg::color_t             in_green,
  input  wire npc_pkg::color_t             in_blue,
  input  wire logic                        out_strobe,
  input  wire logic [npc_pkg::IDX_W-1:0]   out_palette_index,
  input  wire logic                        cfg_wr_en,
  input  wire logic [npc_pkg::CNT_W-1:0]   cfg_wr_data,
  output int                               fail_count,
  output int                               pending
);

  import npc_pkg::*;

  logic [3*COLOR_W-1:0] palette_copy [PALETTE_DEPTH];
  logic [CNT_W-1:0]     entries_in_use;
  logic [IDX_W-1:0]     expected_index_q [$];
  int                   errors;

  initial begin
    errors         = 0;
    entries_in_use = CNT_W'(PALETTE_DEPTH);
    fail_count     = 0;
    pending        = 0;
  end

  function automatic logic [IDX_W-1:0] closest_entry(color_t r, color_t g, color_t b);
    int unsigned          n;
    int unsigned          best_dist;
    int unsigned          cand_dist;
    int                   dr;
    int                   dg;
    int                   db;
    logic [IDX_W-1:0]     best;
    logic [3*COLOR_W-1:0] e;
    n         = entries_in_use;
    best      = '0;
    best_dist = 0;
    if (n == 0) n = 1;
    if (n > PALETTE_DEPTH) n = PALETTE_DEPTH;
    for (int unsigned i = 0; i < n; i++) begin
      e         = palette_copy[i];
      dr        = int'(e[23:16]) - int'(r);
      dg        = int'(e[15:8]) - int'(g);
      db        = int'(e[7:0]) - int'(b);
      cand_dist = dr * dr + dg * dg + db * db;
      if (i == 0 || cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = IDX_W'(i);
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use = CNT_W'(PALETTE_DEPTH);
      expected_index_q.delete();
    end else begin
      if (cfg_wr_en) entries_in_use = cfg_wr_data;
      // result beat first: a new query may be accepted on the strobe cycle
      if (out_strobe) begin
        if (expected_index_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none, actual %0d",
                   $time, out_palette_index);
        end else if (expected_index_q[0] !== out_palette_index) begin
          errors++;
          $display("%0t: palette_index mismatch: expected %0d, actual %0d",
                   $time, expected_index_q[0], out_palette_index);
          void'(expected_index_q.pop_front());
        end else begin
          void'(expected_index_q.pop_front());
        end
      end
      if (start && !busy) begin
        if (in_kind == KIND_LOAD) begin
          if (int'(in_entry_index) < PALETTE_DEPTH)
            palette_copy[in_entry_index] = {in_red, in_green, in_blue};
        end else begin
          expected_index_q.push_back(closest_entry(in_red, in_green, in_blue));
        end
      end
    end
    pending    <= expected_index_q.size();
    fail_count <= errors;
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the nearest palette color core. A directed part
// covers single-entry search, ties, color extremes and the count register
// edge values; random phases then reload entries and query pixels at many
// entry counts with random idle gaps. Checking sits in the checker module.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import npc_pkg::*;

  localparam int TARGET_BEATS = 1750;
  localparam int STALL_LIMIT  = 3000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_kind;
  logic [IDX_W-1:0] in_entry_index;
  color_t           in_red;
  color_t           in_green;
  color_t           in_blue;
  logic             out_strobe;
  logic [IDX_W-1:0] out_palette_index;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;
  int               fail_count;
  int               pending;

  int               beats_sent;
  int               idle_cycles;
  bit               no_idle;
  logic [23:0]      shadow_palette [DEPTH_DEF];

  nearest_palette_color_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_strobe        (out_strobe),
    .out_palette_index (out_palette_index),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  nearest_palette_color_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_entry_index    (in_entry_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_strobe        (out_strobe),
    .out_palette_index (out_palette_index),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic color_t nudge(color_t c);
    int v;
    v = int'(c) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return color_t'(v);
  endfunction

  // drive one beat, hold it until accepted, then maybe idle
  task automatic send_beat(logic kind, logic [IDX_W-1:0] idx, color_t r, color_t g,
                           color_t b);
    int gap;
    start          <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (kind == KIND_LOAD) shadow_palette[idx] = {r, g, b};
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_entry(logic [IDX_W-1:0] idx, logic [23:0] rgb);
    send_beat(KIND_LOAD, idx, rgb[23:16], rgb[15:8], rgb[7:0]);
  endtask

  task automatic query_pixel(logic [23:0] rgb);
    send_beat(KIND_QUERY, IDX_W'($urandom), rgb[23:16], rgb[15:8], rgb[7:0]);
  endtask

  // register writes only with the core idle and no result outstanding
  task automatic set_entries(logic [CNT_W-1:0] count);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count, int beats);
    int          sel;
    logic [23:0] rgb;
    int unsigned span;
    span = (count == 0) ? 1 : ((count > DEPTH_DEF) ? DEPTH_DEF : count);
    for (int k = 0; k < beats; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        // mostly reload inside the searched range, sometimes copy for ties
        if ($urandom_range(0, 3) == 0)
          rgb = shadow_palette[$urandom_range(0, span - 1)];
        else
          rgb = 24'($urandom);
        if ($urandom_range(0, 3) == 0)
          load_entry(IDX_W'($urandom), rgb);
        else
          load_entry(IDX_W'($urandom_range(0, span - 1)), rgb);
      end else if (sel < 55) begin
        rgb = shadow_palette[$urandom_range(0, span - 1)];
        query_pixel(rgb);
      end else if (sel < 75) begin
        rgb = shadow_palette[$urandom_range(0, span - 1)];
        query_pixel({nudge(rgb[23:16]), nudge(rgb[15:8]), nudge(rgb[7:0])});
      end else begin
        query_pixel(24'($urandom));
      end
    end
  endtask

  initial begin
    int          sel;
    int unsigned count;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_kind        <= KIND_LOAD;
    in_entry_index <= '0;
    in_red         <= '0;
    in_green       <= '0;
    in_blue        <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    beats_sent  = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero count searches entry 0 only
    set_entries(CNT_W'(0));
    load_entry(8'd0, 24'h000000);
    query_pixel(24'hFFFFFF);
    load_entry(8'd1, 24'hFFFFFF);
    query_pixel(24'hFFFFFF);
    set_entries(CNT_W'(2));
    query_pixel(24'hFFFFFF);
    query_pixel(24'h000000);
    query_pixel(24'h808080);
    query_pixel(24'h7F7F7F);
    // duplicate entry: lowest index wins the tie
    load_entry(8'd2, 24'h000000);
    set_entries(CNT_W'(3));
    query_pixel(24'h000000);
    load_entry(8'd2, 24'hFF0000);
    query_pixel(24'hFF0000);
    query_pixel(24'h00FF00);
    query_pixel(24'h0000FF);
    query_pixel(24'hFF00FF);
    load_entry(8'hFF, 24'h123456);
    set_entries(CNT_W'(1));
    query_pixel(24'h123456);

    // fill the whole palette before any wide search
    set_entries(CNT_W'(DEPTH_DEF));
    for (int i = 0; i < DEPTH_DEF; i++) load_entry(IDX_W'(i), 24'($urandom));
    random_phase(DEPTH_DEF, 20);

    while (beats_sent < TARGET_BEATS) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0:       count = 0;
        1:       count = 1;
        2:       count = 2;
        3:       count = DEPTH_DEF;
        4:       count = DEPTH_DEF + 1;
        5:       count = (1 << CNT_W) - 1;
        6:       count = $urandom_range(DEPTH_DEF + 1, (1 << CNT_W) - 1);
        7, 8:    count = $urandom_range(1, DEPTH_DEF);
        default: count = $urandom_range(1, 16);
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      set_entries(CNT_W'(count));
      random_phase(count, $urandom_range(20, 60));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/npc_pkg.sv
rtl/nearest_palette_color_core.sv
sim/nearest_palette_color_checker.sv
sim/tb.sv
